/* hdl/ohlcv_pkg.sv */
`timescale 1ns / 1ps
package ohlcv_pkg;
    localparam int Symbols = 256;
    localparam int Slots = 6;
    localparam int SymW = 8;
    localparam int SlotW = 3;
    localparam int EntryW = 11;
    localparam int Depth = Symbols * Slots;
    localparam int ClearW = 12;
    localparam int CntMax = 1023;
    localparam int MsPerMin = 60000;
    localparam logic [9:0] PeriodReset [Slots] =
        '{10'd5, 10'd15, 10'd30, 10'd60, 10'd240, 10'd480};
    localparam logic [SlotW-1:0] LastSlot = SlotW'(Slots - 1);
    localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [SymW-1:0] sym;
        logic [47:0] ts;
        logic [47:0] op;
        logic [47:0] hi;
        logic [47:0] lo;
        logic [47:0] cl;
        logic [47:0] vol;
    } t_item;

    typedef struct packed {
        t_item item;
        logic [Slots-1:0][47:0] pstart;
        logic [Slots-1:0][9:0] mins;
    } t_job;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        F_IDLE, F_DIV, F_PUSH
    } t_front_state;
endpackage

/* hdl/ohlcv_bar_aggregator.sv */
`timescale 1ns / 1ps
// Builds OHLCV bars of six configurable period lengths from one-minute bars per
// symbol and emits each completed bar whose minute count matches its period.
// After reset all 1536 entries of the bar store are cleared, during which no
// word is taken. The front computes period starts with a 33-step restoring
// remainder and takes no new word until it has pushed its result; the back does
// one read-modify-write per slot, takes no new word until it has finished the
// last one, and stalls only while a completed bar waits behind a result that is
// not yet taken. A two-entry queue lies between the two parts. Results of one
// word come out in slot order, the last one marked. The user must write
// configuration only while the block is idle; the block does not enforce this.
module ohlcv_bar_aggregator
    import ohlcv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [7:0] i_symbol_index,
    input  logic [47:0] i_timestamp_ms,
    input  logic [47:0] i_open_price,
    input  logic [47:0] i_high_price,
    input  logic [47:0] i_low_price,
    input  logic [47:0] i_close_price,
    input  logic [47:0] i_traded_volume,
    output logic o_valid,
    input  logic i_ready,
    output logic [2:0] o_slot_index,
    output logic [7:0] o_bar_symbol,
    output logic [47:0] o_period_start_ms,
    output logic [47:0] o_bar_open,
    output logic [47:0] o_bar_high,
    output logic [47:0] o_bar_low,
    output logic [47:0] o_bar_close,
    output logic [47:0] o_bar_volume,
    output logic o_last,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [9:0] i_cfg_data
);
    logic [Slots-1:0][9:0] r_mins;
    t_item w_item;
    logic w_fv, w_fr, w_qv, w_qr, w_clearing, w_take, w_fready;
    t_job w_fjob, w_qjob;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Slots; s++) r_mins[s] <= PeriodReset[s];
        end else if (i_cfg_valid && i_cfg_index < SlotW'(Slots)) begin
            r_mins[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_item = '{sym: i_symbol_index, ts: i_timestamp_ms, op: i_open_price,
                      hi: i_high_price, lo: i_low_price, cl: i_close_price,
                      vol: i_traded_volume};
    assign o_ready = w_fready && !w_clearing;
    assign w_take = i_valid && !w_clearing;

    ohlcv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_take), .o_ready(w_fready),
        .i_item(w_item), .i_mins(r_mins), .o_job_valid(w_fv), .i_job_ready(w_fr),
        .o_job(w_fjob)
    );
    ohlcv_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_ready(w_fr),
        .i_job(w_fjob), .o_valid(w_qv), .i_ready(w_qr), .o_job(w_qjob)
    );
    ohlcv_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_ready(w_qr),
        .i_job(w_qjob), .o_valid(o_valid), .i_ready(i_ready),
        .o_slot_index(o_slot_index), .o_bar_symbol(o_bar_symbol),
        .o_period_start_ms(o_period_start_ms), .o_bar_open(o_bar_open),
        .o_bar_high(o_bar_high), .o_bar_low(o_bar_low), .o_bar_close(o_bar_close),
        .o_bar_volume(o_bar_volume), .o_last(o_last), .o_clearing(w_clearing)
    );

`ifndef SYNTHESIS
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_ready) else $error("word taken during clear");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_slot_index <= LastSlot) else $error("slot out of range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bar_volume))
        else $error("result dropped");
`endif
endmodule

/* hdl/ohlcv_front.sv */
`timescale 1ns / 1ps
module ohlcv_front
    import ohlcv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_item i_item,
    input  logic [Slots-1:0][9:0] i_mins,
    output logic o_job_valid,
    input  logic i_job_ready,
    output t_job o_job
);
    // Period start is ts minus (ts mod len); the remainder is found by restoring
    // division one bit per cycle, for all slots in parallel.
    t_front_state r_state, n_state;
    t_item r_item;
    logic [Slots-1:0][9:0] r_mins;
    logic [Slots-1:0][47:0] r_rem;
    logic [Slots-1:0][63:0] r_shift;
    logic [5:0] r_bit, n_bit;
    logic [Slots-1:0][47:0] n_rem;
    logic [Slots-1:0][63:0] w_len;
    logic [Slots-1:0][47:0] w_pstart;
    logic [64:0] w_trial [Slots];

    always_comb begin
        for (int s = 0; s < Slots; s++) begin
            w_len[s] = 64'(((i_mins[s] == 10'd0) ? 10'd1 : i_mins[s])) * 64'(MsPerMin);
            w_trial[s] = {17'd0, r_rem[s]} - {1'b0, r_shift[s]};
            n_rem[s] = w_trial[s][64] ? r_rem[s] : w_trial[s][47:0];
            w_pstart[s] = r_item.ts - r_rem[s];
        end
    end

    always_comb begin
        n_state = r_state;
        n_bit = r_bit;
        o_ready = 1'b0;
        o_job_valid = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = F_DIV;
                    n_bit = 6'd32;
                end
            end
            F_DIV: begin
                n_bit = r_bit - 6'd1;
                if (r_bit == 6'd0) n_state = F_PUSH;
            end
            F_PUSH: begin
                o_job_valid = 1'b1;
                if (i_job_ready) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_bit <= '0;
        end else begin
            r_state <= n_state;
            r_bit <= n_bit;
        end
    end

    // r_shift holds len << r_bit.
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_item <= i_item;
            r_mins <= i_mins;
            for (int s = 0; s < Slots; s++) begin
                r_rem[s] <= i_item.ts;
                r_shift[s] <= w_len[s] << 32;
            end
        end else if (r_state == F_DIV) begin
            for (int s = 0; s < Slots; s++) begin
                r_rem[s] <= n_rem[s];
                r_shift[s] <= r_shift[s] >> 1;
            end
        end
    end

    assign o_job.item = r_item;
    assign o_job.pstart = w_pstart;
    assign o_job.mins = r_mins;
endmodule

/* hdl/ohlcv_queue.sv */
`timescale 1ns / 1ps
module ohlcv_queue
    import ohlcv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
    end
endmodule

/* hdl/ohlcv_back.sv */
`timescale 1ns / 1ps
module ohlcv_back
    import ohlcv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output logic [SlotW-1:0] o_slot_index,
    output logic [SymW-1:0] o_bar_symbol,
    output logic [47:0] o_period_start_ms,
    output logic [47:0] o_bar_open,
    output logic [47:0] o_bar_high,
    output logic [47:0] o_bar_low,
    output logic [47:0] o_bar_close,
    output logic [47:0] o_bar_volume,
    output logic o_last,
    output logic o_clearing
);
    localparam int RecW = 1 + 6 * 48 + 10;
    typedef struct packed {
        logic vld;
        logic [47:0] ps;
        logic [47:0] op;
        logic [47:0] hi;
        logic [47:0] lo;
        logic [47:0] cl;
        logic [47:0] vol;
        logic [9:0] cnt;
    } t_rec;

    logic [RecW-1:0] r_mem [Depth];
    t_rec r_rd;
    t_back_state r_state, n_state;
    logic [ClearW-1:0] r_clr;
    t_job r_job;
    logic [SlotW-1:0] r_slot, n_slot;
    logic [EntryW-1:0] w_addr;
    logic w_we;
    t_rec w_wr;
    logic w_emit, w_start, w_more;
    logic [48:0] w_sum;
    logic [9:0] w_mins;
    logic [47:0] w_ps;
    logic r_ovalid;
    logic r_pend;
    logic w_ofree, w_block, w_deliver;

    assign w_addr = (r_state == S_CLEAR) ? r_clr[EntryW-1:0]
                  : EntryW'(r_job.item.sym) * EntryW'(Slots) + EntryW'(r_slot);
    assign w_mins = (r_job.mins[r_slot] == 10'd0) ? 10'd1 : r_job.mins[r_slot];
    assign w_ps = r_job.pstart[r_slot];
    assign w_start = !r_rd.vld || (r_rd.ps != w_ps);
    assign w_emit = r_rd.vld && (r_rd.ps != w_ps) && (r_rd.cnt == w_mins);
    assign w_sum = {1'b0, r_rd.vol} + {1'b0, r_job.item.vol};
    assign w_more = (r_slot != LastSlot);
    assign w_ofree = !r_ovalid || i_ready;
    assign w_block = (r_state == S_EXEC) && w_emit && r_pend && !w_ofree;
    assign w_deliver = ((r_state == S_EXEC) && !w_block && w_emit && r_pend)
                     || ((r_state == S_EMIT) && r_pend && w_ofree);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_clearing = (r_state == S_CLEAR);

    always_comb begin
        w_wr.vld = 1'b1;
        if (w_start) begin
            w_wr.ps = w_ps;
            w_wr.op = r_job.item.op;
            w_wr.hi = r_job.item.hi;
            w_wr.lo = r_job.item.lo;
            w_wr.cl = r_job.item.cl;
            w_wr.vol = r_job.item.vol;
            w_wr.cnt = 10'd1;
        end else begin
            w_wr.ps = r_rd.ps;
            w_wr.op = r_rd.op;
            w_wr.hi = (r_job.item.hi > r_rd.hi) ? r_job.item.hi : r_rd.hi;
            w_wr.lo = (r_job.item.lo < r_rd.lo) ? r_job.item.lo : r_rd.lo;
            w_wr.cl = r_job.item.cl;
            w_wr.vol = w_sum[48] ? Max48 : w_sum[47:0];
            w_wr.cnt = (r_rd.cnt == 10'(CntMax)) ? r_rd.cnt : r_rd.cnt + 10'd1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot = r_slot;
        w_we = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_clr == ClearW'(Depth - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                n_slot = '0;
                if (i_valid) n_state = S_READ;
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (!w_block) begin
                    w_we = 1'b1;
                    if (w_more) begin
                        n_slot = r_slot + SlotW'(1);
                        n_state = S_READ;
                    end else n_state = S_EMIT;
                end
            end
            S_EMIT: if (!r_pend || w_ofree) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_slot <= '0;
            r_ovalid <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot <= n_slot;
            if (r_state == S_CLEAR) r_clr <= r_clr + ClearW'(1);
            if (w_deliver) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_EXEC && !w_block && w_emit) begin
                r_pend <= 1'b1;
            end else if (r_state == S_EMIT && w_deliver) begin
                r_pend <= 1'b0;
            end
        end
    end

    // A found bar is held in a staging register; it goes out as non-last when a
    // later slot finds another bar, or as last at the end of the word.
    logic [SlotW-1:0] r_ps_slot;
    t_rec r_stage;
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) r_job <= i_job;
        if (r_state == S_EXEC && !w_block && w_emit) begin
            r_stage <= r_rd;
            r_ps_slot <= r_slot;
        end
        if (w_deliver) begin
            o_slot_index <= r_ps_slot;
            o_bar_symbol <= r_job.item.sym;
            o_period_start_ms <= r_stage.ps;
            o_bar_open <= r_stage.op;
            o_bar_high <= r_stage.hi;
            o_bar_low <= r_stage.lo;
            o_bar_close <= r_stage.cl;
            o_bar_volume <= r_stage.vol;
            o_last <= (r_state == S_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= (r_state == S_CLEAR) ? '0 : RecW'(w_wr);
        r_rd <= t_rec'(r_mem[w_addr]);
    end
endmodule

/* tb/ohlcv_bar_checker.sv */
`timescale 1ns / 1ps
module ohlcv_bar_checker
    import ohlcv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [7:0]  i_symbol_index,
    input  logic [47:0] i_timestamp_ms,
    input  logic [47:0] i_open_price,
    input  logic [47:0] i_high_price,
    input  logic [47:0] i_low_price,
    input  logic [47:0] i_close_price,
    input  logic [47:0] i_traded_volume,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [2:0]  o_slot_index,
    input  logic [7:0]  o_bar_symbol,
    input  logic [47:0] o_period_start_ms,
    input  logic [47:0] o_bar_open,
    input  logic [47:0] o_bar_high,
    input  logic [47:0] o_bar_low,
    input  logic [47:0] o_bar_close,
    input  logic [47:0] o_bar_volume,
    input  logic        o_last,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    output int          fail_count,
    output int          bars_pending
);
    typedef struct {
        logic [2:0]  slot;
        logic [7:0]  sym;
        logic [47:0] pstart;
        logic [47:0] op;
        logic [47:0] hi;
        logic [47:0] lo;
        logic [47:0] cl;
        logic [47:0] vol;
        logic        last;
    } bar_t;

    bar_t        bar_q[$];
    logic [9:0]  period_len[Slots];
    bit          run_valid[Depth];
    logic [47:0] run_pstart[Depth];
    logic [47:0] run_open[Depth];
    logic [47:0] run_high[Depth];
    logic [47:0] run_low[Depth];
    logic [47:0] run_close[Depth];
    logic [47:0] run_vol[Depth];
    logic [9:0]  run_count[Depth];

    function automatic void accumulate_bar(input logic [7:0] sym, input logic [47:0] ts,
                                           input logic [47:0] op, input logic [47:0] hi,
                                           input logic [47:0] lo, input logic [47:0] cl,
                                           input logic [47:0] vol);
        int e;
        int n;
        longint unsigned mins;
        longint unsigned len;
        logic [47:0] ps;
        logic [48:0] sum;
        bar_t b;
        n = 0;
        for (int s = 0; s < Slots; s++) begin
            e = int'(sym) * Slots + s;
            mins = (period_len[s] == 0) ? 1 : period_len[s];
            len = mins * 60000;
            ps = 48'((longint'(ts) / len) * len);
            if (run_valid[e] && run_pstart[e] == ps) begin
                if (hi > run_high[e]) run_high[e] = hi;
                if (lo < run_low[e]) run_low[e] = lo;
                run_close[e] = cl;
                sum = {1'b0, run_vol[e]} + {1'b0, vol};
                run_vol[e] = sum[48] ? Max48 : sum[47:0];
                if (run_count[e] != 10'(CntMax)) run_count[e]++;
            end else begin
                if (run_valid[e] && longint'(run_count[e]) == mins) begin
                    b.slot = 3'(s);
                    b.sym = sym;
                    b.pstart = run_pstart[e];
                    b.op = run_open[e];
                    b.hi = run_high[e];
                    b.lo = run_low[e];
                    b.cl = run_close[e];
                    b.vol = run_vol[e];
                    b.last = 1'b0;
                    bar_q.push_back(b);
                    n++;
                end
                run_valid[e] = 1'b1;
                run_pstart[e] = ps;
                run_open[e] = op;
                run_high[e] = hi;
                run_low[e] = lo;
                run_close[e] = cl;
                run_vol[e] = vol;
                run_count[e] = 10'd1;
            end
        end
        if (n > 0) bar_q[bar_q.size() - 1].last = 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [47:0] exp_v,
                               input logic [47:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        bar_t b;
        if (!i_rst_n) begin
            for (int s = 0; s < Slots; s++) period_len[s] = PeriodReset[s];
            for (int e = 0; e < Depth; e++) run_valid[e] = 1'b0;
            bar_q.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (bar_q.size() == 0) begin
                    $error("bar_slot: unexpected word, got slot %0d symbol %0d",
                           o_slot_index, o_bar_symbol);
                    fail_count++;
                end else begin
                    b = bar_q.pop_front();
                    check_field("slot_index", 48'(b.slot), 48'(o_slot_index));
                    check_field("bar_symbol", 48'(b.sym), 48'(o_bar_symbol));
                    check_field("period_start_ms", b.pstart, o_period_start_ms);
                    check_field("bar_open", b.op, o_bar_open);
                    check_field("bar_high", b.hi, o_bar_high);
                    check_field("bar_low", b.lo, o_bar_low);
                    check_field("bar_close", b.cl, o_bar_close);
                    check_field("bar_volume", b.vol, o_bar_volume);
                    check_field("last", 48'(b.last), 48'(o_last));
                end
            end
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < Slots)
                period_len[i_cfg_index] = i_cfg_data;
            if (i_valid && o_ready && int'(i_symbol_index) < Symbols)
                accumulate_bar(i_symbol_index, i_timestamp_ms, i_open_price, i_high_price,
                               i_low_price, i_close_price, i_traded_volume);
        end
        bars_pending = bar_q.size();
    end
endmodule

/* tb/ohlcv_bar_aggregator_tb.sv */
`timescale 1ns / 1ps
module ohlcv_bar_aggregator_tb;
    import ohlcv_pkg::*;

    localparam longint unsigned MinMs = 60000;
    localparam int CycleLimit = 3000000;
    localparam int SettleCycles = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_symbol_index;
    logic [47:0] i_timestamp_ms;
    logic [47:0] i_open_price;
    logic [47:0] i_high_price;
    logic [47:0] i_low_price;
    logic [47:0] i_close_price;
    logic [47:0] i_traded_volume;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_slot_index;
    logic [7:0]  o_bar_symbol;
    logic [47:0] o_period_start_ms;
    logic [47:0] o_bar_open;
    logic [47:0] o_bar_high;
    logic [47:0] o_bar_low;
    logic [47:0] o_bar_close;
    logic [47:0] o_bar_volume;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;

    int fail_count;
    int bars_pending;
    bit steady;
    bit hold_req;
    longint unsigned minute_of[256];
    logic [7:0] sym_pool[4];

    ohlcv_bar_aggregator i_dut (.*);
    ohlcv_bar_checker i_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CycleLimit) begin
                $display("ohlcv_bar_aggregator_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end else begin
                stall = steady ? 0 : $urandom_range(0, 9);
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic send_bar(input logic [7:0] sym, input logic [47:0] ts,
                            input logic [47:0] op, input logic [47:0] hi,
                            input logic [47:0] lo, input logic [47:0] cl,
                            input logic [47:0] vol);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_symbol_index <= sym;
        i_timestamp_ms <= ts;
        i_open_price <= op;
        i_high_price <= hi;
        i_low_price <= lo;
        i_close_price <= cl;
        i_traded_volume <= vol;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_bars();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (bars_pending != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_periods(input logic [9:0] p0, input logic [9:0] p1,
                                 input logic [9:0] p2, input logic [9:0] p3,
                                 input logic [9:0] p4, input logic [9:0] p5);
        logic [9:0] vals[Slots];
        vals = '{p0, p1, p2, p3, p4, p5};
        drain_bars();
        for (int r = 0; r < Slots; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_bars(input int count);
        logic [7:0] sym;
        logic [47:0] ts;
        logic [47:0] vol;
        int pick;
        for (int k = 0; k < count; k++) begin
            sym = sym_pool[$urandom_range(0, 3)];
            pick = $urandom_range(0, 99);
            if (pick < 80) minute_of[sym] += 1;
            else if (pick < 88) ;
            else if (pick < 94) minute_of[sym] += $urandom_range(2, 600);
            else if (pick < 97) minute_of[sym] -= $urandom_range(1, 30);
            if (pick >= 97) begin
                ts = rand48();
                minute_of[sym] = longint'(ts) / MinMs;
            end else begin
                ts = 48'(minute_of[sym] * MinMs + $urandom_range(0, 59999));
            end
            vol = ($urandom_range(0, 19) == 0) ? Max48 - 48'($urandom_range(0, 9)) : rand48();
            send_bar(sym, ts, rand48(), rand48(), rand48(), rand48(), vol);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_symbol_index <= '0;
        i_timestamp_ms <= '0;
        i_open_price <= '0;
        i_high_price <= '0;
        i_low_price <= '0;
        i_close_price <= '0;
        i_traded_volume <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        steady = 1'b0;
        hold_req = 1'b0;
        for (int s = 0; s < 256; s++) minute_of[s] = longint'($urandom);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_bar(8'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0);
        send_bar(8'd255, Max48, Max48, Max48, Max48, Max48, Max48);
        for (int m = 0; m < 6; m++)
            send_bar(8'd3, 48'(m * MinMs + 17), rand48(), 48'(m * 1000), 48'(99 - m),
                     rand48(), Max48);
        send_bar(8'd255, 48'd5, 48'd1, 48'd2, 48'd3, 48'd4, 48'd5);
        send_bar(8'd0, 48'd59999, 48'd7, 48'd7, 48'd7, 48'd7, 48'd7);

        write_periods(10'd0, 10'd1, 10'd1023, 10'd1000, 10'd2, 10'd3);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= 3'd7;
        i_cfg_data <= 10'd1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        for (int m = 0; m < 5; m++)
            send_bar(8'd9, 48'(m * MinMs), rand48(), rand48(), rand48(), rand48(), rand48());
        send_bar(8'd9, 48'd1, 48'd1, 48'd1, 48'd1, 48'd1, 48'd1);

        sym_pool = '{8'd0, 8'd255, 8'd1, 8'd128};
        random_bars(80);
        write_periods(10'd5, 10'd15, 10'd30, 10'd60, 10'd240, 10'd480);
        sym_pool = '{8'd2, 8'd2, 8'd77, 8'd200};
        random_bars(40);
        hold_req = 1'b1;
        random_bars(30);

        write_periods(10'd2, 10'd1, 10'd1000, 10'd3, 10'd1, 10'd5);
        sym_pool = '{8'd4, 8'd5, 8'd6, 8'd4};
        random_bars(40);
        drain_bars();
        random_bars(40);

        write_periods(10'd1, 10'd1, 10'd1, 10'd2, 10'd2, 10'd1023);
        steady = 1'b1;
        for (int k = 0; k < 40; k++)
            send_bar(8'd11, 48'($urandom_range(0, 61379999)), rand48(), rand48(),
                     rand48(), rand48(), rand48());
        send_bar(8'd11, 48'(5 * 61380000), 48'd1, 48'd2, 48'd3, 48'd4, 48'd5);
        random_bars(40);
        steady = 1'b0;
        sym_pool = '{8'd11, 8'd12, 8'd13, 8'd255};
        random_bars(45);

        drain_bars();
        if (fail_count == 0) begin
            $display("ohlcv_bar_aggregator_tb OK");
        end else begin
            $display("ohlcv_bar_aggregator_tb NOT OK");
        end
        $finish;
    end
endmodule
